FILE: sv/mafb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mafb_pkg;

    // Widest frame that margin art can match
    localparam int unsigned MaxWidth = 4096;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ART_PRESENT    = 3'd0,
        CFG_FRAME_WIDTH    = 3'd1,
        CFG_MARGIN_WIDTH   = 3'd2,
        CFG_BRIGHTNESS     = 3'd3,
        CFG_BACKDROP_COLOR = 3'd4
    } t_cfg_index;

    localparam logic [3:0]  FullLevel  = 4'd15;
    localparam logic [31:0] RgbMask    = 32'h00ff_ffff;
    localparam logic [7:0]  AlphaOpaque = 8'hff;
    localparam logic [7:0]  AlphaClear  = 8'h00;
    localparam logic [7:0]  RoundHalf   = 8'd127;

    // Scale factor for floor(c * level / 15): (c * level * 2185) >> 15
    localparam int unsigned FadeShift = 15;
    localparam int unsigned FadeRecip = 2185;

    typedef logic [FadeShift-1:0] t_fade_k;

    function automatic t_fade_k fade_k(input logic [3:0] level);
        fade_k = t_fade_k'(level * FadeRecip);
    endfunction

    // Blend product stage: one 16-bit term per color channel
    typedef struct packed {
        logic        valid;
        logic        replaced;
        logic        opaque;
        logic        clear;
        logic [31:0] src;
        logic [31:0] dst;
        logic [2:0][15:0] term;
    } t_blend_stage;

endpackage

`default_nettype wire

FILE: sv/margin_art_fade_and_blend_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Margin art compositor, one pixel per clock.
// Input channel: present i_column, i_frame_pixel and i_art_pixel with start high;
// an item is taken at each clock edge where start is high and busy is low.
// busy stays low, so a new item may be presented every cycle.
// Configuration channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Index 0 art_present, 1 frame_width, 2 margin columns per side,
// 3 brightness, 4 backdrop_color; other indexes are dropped. Write only while
// no pixel is in flight.
// Results: o_pixel_out and o_replaced appear with o_valid high for exactly one
// cycle per item, registered through the pipeline stages, and come out in order.
// The pipeline has four register stages: input capture, fade multiply,
// blend multiply, divide-by-255 and add. Throughput is one item per cycle.
// The receiver cannot stall; results are never held.
// Reset (synchronous, active low) empties the pipeline and sets the registers
// to art_present 0, frame_width 0, margin 0, brightness 15, backdrop 0.
module margin_art_fade_and_blend_top
    import mafb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] i_column,
    input  wire logic [31:0] i_frame_pixel,
    input  wire logic [31:0] i_art_pixel,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic [31:0]      o_pixel_out,
    output logic             o_replaced
);

    // Configuration registers
    logic        r_art_present;
    logic [12:0] r_frame_width;
    logic [11:0] r_margin_cols;
    logic [3:0]  r_brightness;
    logic [31:0] r_backdrop;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Write configuration, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_art_present  <= 1'b0;
            r_frame_width  <= '0;
            r_margin_cols  <= '0;
            r_brightness   <= FullLevel;
            r_backdrop     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ART_PRESENT:    r_art_present  <= i_cfg_data[0];
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data[12:0];
                CFG_MARGIN_WIDTH:   r_margin_cols  <= i_cfg_data[11:0];
                CFG_BRIGHTNESS:     r_brightness   <= i_cfg_data[3:0];
                CFG_BACKDROP_COLOR: r_backdrop     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: capture the item
    logic        r_s0_valid;
    logic [11:0] r_s0_column;
    logic [31:0] r_s0_fpx;
    logic [31:0] r_s0_apx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_column <= i_column;
        r_s0_fpx    <= i_frame_pixel;
        r_s0_apx    <= i_art_pixel;
    end

    // Stage 1: decide replacement and fade the art
    logic        n_active;
    logic        n_in_margin;
    logic        n_match;
    logic [12:0] n_right_edge;
    logic [13:0] n_twice_margin;
    t_fade_k     n_k;
    logic [22:0] n_prod [3];
    logic [31:0] n_faded;

    always_comb begin
        n_twice_margin = {1'b0, r_margin_cols, 1'b0};
        n_active = r_art_present && (r_brightness != '0) && (r_margin_cols != '0) &&
                   ({1'b0, r_frame_width} > n_twice_margin) &&
                   (r_frame_width <= 13'(MaxWidth));
        n_right_edge = r_frame_width - {1'b0, r_margin_cols};
        n_in_margin  = (r_s0_column < r_margin_cols) ||
                       (({1'b0, r_s0_column} < r_frame_width) &&
                        ({1'b0, r_s0_column} >= n_right_edge));
        n_match = (r_s0_fpx == r_backdrop) || ((r_s0_fpx & RgbMask) == '0);

        n_k = fade_k(r_brightness);
        n_faded[31:24] = r_s0_apx[31:24];
        for (int ch = 0; ch < 3; ch++) begin
            n_prod[ch] = 23'(r_s0_apx[ch*8 +: 8]) * 23'(n_k);
            n_faded[ch*8 +: 8] = (r_brightness == FullLevel) ?
                                 r_s0_apx[ch*8 +: 8] : n_prod[ch][22:15];
        end
    end

    logic        r_s1_valid;
    logic        r_s1_replaced;
    logic [31:0] r_s1_src;
    logic [31:0] r_s1_dst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_replaced <= n_active && n_in_margin && n_match;
        r_s1_src      <= n_faded;
        r_s1_dst      <= r_s0_fpx;
    end

    // Stage 2: multiply frame pixel channels by inverse alpha
    t_blend_stage n_s2;
    t_blend_stage r_s2;
    logic [7:0]   n_inv;

    always_comb begin
        n_inv         = AlphaOpaque - r_s1_src[31:24];
        n_s2.valid    = r_s1_valid;
        n_s2.replaced = r_s1_replaced;
        n_s2.opaque   = (r_s1_src[31:24] == AlphaOpaque);
        n_s2.clear    = (r_s1_src[31:24] == AlphaClear);
        n_s2.src      = r_s1_src;
        n_s2.dst      = r_s1_dst;
        for (int ch = 0; ch < 3; ch++) begin
            n_s2.term[ch] = 16'(r_s1_dst[ch*8 +: 8]) * 16'(n_inv) + 16'(RoundHalf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: divide by 255, add source, select result
    logic [16:0] n_div_sum [3];
    logic [31:0] n_blend;
    logic [31:0] n_pixel;

    always_comb begin
        n_blend[31:24] = AlphaOpaque;
        for (int ch = 0; ch < 3; ch++) begin
            n_div_sum[ch] = 17'(r_s2.term[ch]) + 17'(r_s2.term[ch][15:8]) + 17'd1;
            n_blend[ch*8 +: 8] = r_s2.src[ch*8 +: 8] + n_div_sum[ch][15:8];
        end
        if (!r_s2.replaced) begin
            n_pixel = r_s2.dst;
        end else if (r_s2.opaque) begin
            n_pixel = r_s2.src;
        end else if (r_s2.clear) begin
            n_pixel = r_s2.dst;
        end else begin
            n_pixel = n_blend;
        end
    end

    logic        r_out_valid;
    logic        r_out_replaced;
    logic [31:0] r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pixel    <= n_pixel;
        r_out_replaced <= r_s2.replaced;
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_replaced  = r_out_replaced;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mafb_pkg::*;

    localparam int unsigned ClockPeriod = 20;
    localparam int unsigned PipeDepth = 4;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned RandomPhases = 10;
    localparam int unsigned PixelsPerPhase = 155;

    // Register indexes past the end of the list; writes there are dropped
    localparam logic [2:0] CfgSpareFirst = 3'd5;
    localparam logic [2:0] CfgSpareLast = 3'd7;

    typedef struct packed {
        logic [31:0] pixel;
        logic        replaced;
    } t_pixel_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [11:0] i_column = '0;
    logic [31:0] i_frame_pixel = '0;
    logic [31:0] i_art_pixel = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        busy;
    logic        o_cfg_ready;
    logic        o_valid;
    logic [31:0] o_pixel_out;
    logic        o_replaced;

    // Shadow copy of the block's registers
    logic        shadow_art_on;
    logic [12:0] shadow_frame_width;
    logic [11:0] shadow_margin;
    logic [3:0]  shadow_level;
    logic [31:0] shadow_backdrop;

    t_pixel_result pending_pixels[$];
    int unsigned   fail_count = 0;
    int unsigned   cycle_count = 0;
    bit            sender_gaps_on = 1'b1;

    margin_art_fade_and_blend_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_column      (i_column),
        .i_frame_pixel (i_frame_pixel),
        .i_art_pixel   (i_art_pixel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_replaced    (o_replaced)
    );

    always #(ClockPeriod / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL margin_art_fade_and_blend_top");
            $finish;
        end
    end

    // Dim the art, then lay it source-over onto the frame pixel
    function automatic t_pixel_result blend_margin_pixel(
        input logic [11:0] col,
        input logic [31:0] frame_px,
        input logic [31:0] art_px
    );
        t_pixel_result res;
        int unsigned   fw;
        int unsigned   mw;
        int unsigned   alpha;
        int unsigned   inv;
        int unsigned   s;
        int unsigned   d;
        logic          active;
        logic          in_margin;
        logic [31:0]   faded;

        fw = shadow_frame_width;
        mw = shadow_margin;
        active = shadow_art_on && shadow_level != 0 && mw != 0 && fw > 2 * mw
            && fw <= MaxWidth;
        in_margin = col < mw || (col < fw && col >= fw - mw);
        res.pixel = frame_px;
        res.replaced = 1'b0;
        if (active && in_margin
                && (frame_px == shadow_backdrop || (frame_px & RgbMask) == 0)) begin
            faded = art_px;
            if (shadow_level != FullLevel) begin
                for (int ch = 0; ch < 3; ch++) begin
                    faded[ch*8 +: 8] = 8'((art_px[ch*8 +: 8] * shadow_level) / 15);
                end
            end
            alpha = faded[31:24];
            if (alpha == AlphaOpaque) begin
                res.pixel = faded;
            end else if (alpha != AlphaClear) begin
                inv = 255 - alpha;
                res.pixel[31:24] = AlphaOpaque;
                for (int ch = 0; ch < 3; ch++) begin
                    s = faded[ch*8 +: 8];
                    d = frame_px[ch*8 +: 8];
                    res.pixel[ch*8 +: 8] = 8'(s + (d * inv + RoundHalf) / 255);
                end
            end
            res.replaced = 1'b1;
        end
        return res;
    endfunction

    // Check each result, queue a prediction per accepted pixel, track registers
    always @(posedge i_clk) begin : check_results
        t_pixel_result want;
        if (!i_rst_n) begin
            shadow_art_on <= 1'b0;
            shadow_frame_width <= '0;
            shadow_margin <= '0;
            shadow_level <= FullLevel;
            shadow_backdrop <= '0;
            pending_pixels.delete();
        end else begin
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result pixel_out %h replaced %0b",
                        $time, o_pixel_out, o_replaced);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_out !== want.pixel) begin
                        $display("%0t: pixel_out expected %h actual %h",
                            $time, want.pixel, o_pixel_out);
                        fail_count++;
                    end
                    if (o_replaced !== want.replaced) begin
                        $display("%0t: replaced expected %0b actual %0b",
                            $time, want.replaced, o_replaced);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                pending_pixels.push_back(
                    blend_margin_pixel(i_column, i_frame_pixel, i_art_pixel));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ART_PRESENT:    shadow_art_on <= i_cfg_data[0];
                    CFG_FRAME_WIDTH:    shadow_frame_width <= i_cfg_data[12:0];
                    CFG_MARGIN_WIDTH:   shadow_margin <= i_cfg_data[11:0];
                    CFG_BRIGHTNESS:     shadow_level <= i_cfg_data[3:0];
                    CFG_BACKDROP_COLOR: shadow_backdrop <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Present one pixel after an optional gap and hold it until taken
    task automatic send_pixel(
        input logic [11:0] col,
        input logic [31:0] frame_px,
        input logic [31:0] art_px
    );
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_column <= col;
        i_frame_pixel <= frame_px;
        i_art_pixel <= art_px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop sending and wait for every pending pixel to come back
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_setup(
        input logic        art_on,
        input logic [12:0] fw,
        input logic [11:0] mw,
        input logic [3:0]  level,
        input logic [31:0] backdrop
    );
        drain_pipeline();
        write_reg(CFG_ART_PRESENT, {31'($urandom), art_on});
        write_reg(CFG_FRAME_WIDTH, {19'($urandom), fw});
        write_reg(CFG_MARGIN_WIDTH, {20'($urandom), mw});
        write_reg(CFG_BRIGHTNESS, {28'($urandom), level});
        write_reg(CFG_BACKDROP_COLOR, backdrop);
    endtask

    // Registers at reset: nothing is replaced, even on backdrop pixels
    task automatic test_reset_defaults();
        send_pixel(12'd0, 32'h0000_0000, 32'hff12_3456);
        send_pixel(12'd4095, 32'hff00_0000, 32'h80ff_ffff);
    endtask

    // Margin boundaries, alpha shortcuts and channel wrap at full brightness
    task automatic test_margin_edges();
        load_setup(1'b1, 13'd4096, 12'd2047, FullLevel, 32'h40c0_c0c0);
        send_pixel(12'd0, 32'h40c0_c0c0, 32'hff12_3456);
        send_pixel(12'd2046, 32'hff00_0000, 32'h00ab_cdef);
        send_pixel(12'd2047, 32'h40c0_c0c0, 32'hff12_3456);
        send_pixel(12'd2048, 32'h0000_0000, 32'h8011_2233);
        send_pixel(12'd2049, 32'h7f00_0000, 32'h80ff_ffff);
        send_pixel(12'd4095, 32'h40c0_c0c0, 32'h80ff_ffff);
        send_pixel(12'd4095, 32'hffff_ffff, 32'hffff_ffff);
        send_pixel(12'd0, 32'h0000_0000, 32'h0100_0000);
    endtask

    // A few fade levels, zero switching the block off
    task automatic test_fade_levels();
        logic [3:0] levels[4] = '{4'd0, 4'd1, 4'd7, 4'd14};
        load_setup(1'b1, 13'd640, 12'd64, FullLevel, 32'hffff_ffff);
        foreach (levels[i]) begin
            drain_pipeline();
            write_reg(CFG_BRIGHTNESS, {28'hfff_ffff, levels[i]});
            send_pixel(12'd10, 32'hffff_ffff, 32'hc0ff_80ff);
        end
    endtask

    // Setups that leave the block off, masked writes and dropped indexes
    task automatic test_inactive_setups();
        load_setup(1'b0, 13'd256, 12'd16, FullLevel, 32'h0000_0000);
        send_pixel(12'd0, 32'h0000_0000, 32'hff00_ff00);
        load_setup(1'b1, 13'd256, 12'd0, FullLevel, 32'h0000_0000);
        send_pixel(12'd0, 32'h0000_0000, 32'hff00_ff00);
        load_setup(1'b1, 13'd256, 12'd128, FullLevel, 32'h0000_0000);
        send_pixel(12'd0, 32'h0000_0000, 32'hff00_ff00);
        load_setup(1'b1, 13'd4097, 12'd1, FullLevel, 32'h0000_0000);
        send_pixel(12'd0, 32'h0000_0000, 32'hff00_ff00);
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, 32'hffff_ffff);
        write_reg(CFG_MARGIN_WIDTH, 32'hffff_ffff);
        send_pixel(12'd0, 32'h0000_0000, 32'hff00_ff00);
        // Columns at and past the frame edge
        load_setup(1'b1, 13'd100, 12'd10, FullLevel, 32'h0000_0000);
        send_pixel(12'd100, 32'h0000_0000, 32'hff00_ff00);
        send_pixel(12'd4095, 32'h0000_0000, 32'hff00_ff00);
        drain_pipeline();
        for (int idx = CfgSpareFirst; idx <= CfgSpareLast; idx++) begin
            write_reg(3'(idx), 32'h0000_0000);
        end
        send_pixel(12'd95, 32'h0000_0000, 32'h9933_6699);
    endtask

    // Random setups, each followed by a stream of mostly margin pixels
    task automatic test_random_stream();
        int unsigned mode;
        int unsigned fw;
        int unsigned mw;
        int unsigned col;
        logic [3:0]  level;
        logic [31:0] backdrop;
        logic [31:0] frame_px;
        logic [31:0] art_px;
        for (int phase = 0; phase < RandomPhases; phase++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) fw = $urandom_range(4097, 8191);
            else if (mode == 1) fw = MaxWidth;
            else if (mode <= 5) fw = $urandom_range(3, 64);
            else fw = $urandom_range(16, 4096);
            if (mode == 2) mw = $urandom_range(fw / 2, 4095);
            else mw = $urandom_range(1, (fw - 1) / 2);
            level = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            backdrop = $urandom;
            if ($urandom_range(0, 3) == 0) backdrop[23:0] = '0;
            load_setup($urandom_range(0, 7) != 0, 13'(fw), 12'(mw), level, backdrop);
            sender_gaps_on = (phase % 3) != 1;
            for (int n = 0; n < PixelsPerPhase; n++) begin
                mode = $urandom_range(0, 9);
                if (mode <= 3 && mw != 0) col = $urandom_range(0, mw - 1);
                else if (mode <= 6 && fw > mw) col = $urandom_range(fw - mw, fw - 1);
                else col = $urandom_range(0, 4095);
                if (col > 4095) col = $urandom_range(0, 4095);
                mode = $urandom_range(0, 9);
                if (mode <= 3) frame_px = backdrop;
                else if (mode <= 6) frame_px = {8'($urandom), 24'h0};
                else frame_px = $urandom;
                art_px = $urandom;
                mode = $urandom_range(0, 4);
                if (mode <= 1) art_px[31:24] = AlphaOpaque;
                else if (mode == 2) art_px[31:24] = AlphaClear;
                send_pixel(12'(col), frame_px, art_px);
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_margin_edges();
        test_fade_levels();
        test_inactive_setups();
        test_random_stream();
        drain_pipeline();
        repeat (PipeDepth * 2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS margin_art_fade_and_blend_top");
        end else begin
            $display("FAIL margin_art_fade_and_blend_top");
        end
        $finish;
    end

endmodule
